// ===== rtl/core/pct_pkg.sv =====
package pct_pkg;

  typedef enum logic [1:0] {
    KIND_NUMBER   = 2'd0,
    KIND_FUNC     = 2'd1,
    KIND_EXT_FUNC = 2'd2
  } cell_kind_e;

  typedef struct packed {
    cell_kind_e         kind;
    logic [7:0]         func_code;
    logic signed [63:0] mantissa;
    logic [4:0]         scale;
    logic               last;
  } result_t;

  // up to two results per text byte, res0 first
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0]  CHAR_DOT        = 8'h2E;
  localparam logic [7:0]  CHAR_ZERO       = 8'd48;
  localparam logic [7:0]  CHAR_NINE       = 8'd57;
  localparam logic [7:0]  EXTEND_RESET    = 8'd35;
  localparam logic [2:0]  FRACTION_LIMIT  = 3'd6;
  localparam logic [4:0]  SCALE_MAX       = 5'd18;
  localparam logic [62:0] DIGIT_MAX       = {63{1'b1}};

  localparam logic        REG_EXTEND_CHAR = 1'b0;

endpackage

// ===== rtl/core/pct_cfg_regs.sv =====
module pct_cfg_regs
  import pct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  extend_char_o
);

  logic [7:0] extend_char_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_EXTEND_CHAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extend_char_q <= EXTEND_RESET;
    end else if (wr_en) begin
      extend_char_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_EXTEND_CHAR) begin
      prdata = {24'd0, extend_char_q};
    end
  end

  assign extend_char_o = extend_char_q;

endmodule

// ===== rtl/core/pct_core.sv =====
module pct_core
  import pct_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic [7:0] extend_char_i,
  input  logic       room_i,
  output push_t      push_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        proc;

  logic        in_number_q, in_number_d;
  logic        is_negative_q, is_negative_d;
  logic [62:0] digit_value_q, digit_value_d;
  logic [2:0]  fraction_count_q, fraction_count_d;
  logic [4:0]  scale_count_q, scale_count_d;
  logic        extend_pending_q, extend_pending_d;

  logic        cur_neg;
  logic [62:0] cur_dv;
  logic [2:0]  cur_fc;
  logic [4:0]  cur_sc;
  logic        is_digit;
  logic        is_num;
  logic [66:0] prod;
  push_t       push;

  function automatic result_t make_func(cell_kind_e kind, logic [7:0] code);
    result_t r;
    r.kind      = kind;
    r.func_code = code;
    r.mantissa  = '0;
    r.scale     = '0;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic result_t make_number(logic neg, logic [62:0] dv, logic [4:0] sc);
    result_t r;
    r.kind      = KIND_NUMBER;
    r.func_code = '0;
    r.mantissa  = neg ? -$signed({1'b0, dv}) : $signed({1'b0, dv});
    r.scale     = sc;
    r.last      = 1'b0;
    return r;
  endfunction

  assign proc       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= text_byte_i;
    end
  end

  assign is_digit = (byte_q >= CHAR_ZERO) && (byte_q <= CHAR_NINE);
  assign is_num   = is_digit || (byte_q == CHAR_UNDERSCORE) || (byte_q == CHAR_DOT);

  // a number starts afresh when not already inside one
  assign cur_neg = in_number_q ? is_negative_q    : 1'b0;
  assign cur_dv  = in_number_q ? digit_value_q    : '0;
  assign cur_fc  = in_number_q ? fraction_count_q : '0;
  assign cur_sc  = in_number_q ? scale_count_q    : '0;

  // value * 10 + digit; the digit is the low nibble of the ASCII code
  assign prod = ({4'd0, cur_dv} << 3) + ({4'd0, cur_dv} << 1) + {63'd0, byte_q[3:0]};

  always_comb begin
    in_number_d      = in_number_q;
    is_negative_d    = is_negative_q;
    digit_value_d    = digit_value_q;
    fraction_count_d = fraction_count_q;
    scale_count_d    = scale_count_q;
    extend_pending_d = extend_pending_q;
    push             = '0;
    if (proc) begin
      if (extend_pending_q) begin
        extend_pending_d = 1'b0;
        push.count       = 2'd1;
        push.res0        = make_func(KIND_EXT_FUNC, byte_q);
      end else if (is_num) begin
        in_number_d      = 1'b1;
        is_negative_d    = cur_neg;
        digit_value_d    = cur_dv;
        fraction_count_d = cur_fc;
        scale_count_d    = cur_sc;
        if (byte_q == CHAR_UNDERSCORE) begin
          is_negative_d = 1'b1;
        end else if (byte_q == CHAR_DOT) begin
          fraction_count_d = 3'd1;
        end else begin
          digit_value_d = (prod[66:63] != 4'd0) ? DIGIT_MAX : prod[62:0];
          if (cur_fc != 3'd0) begin
            scale_count_d    = (cur_sc < SCALE_MAX) ? cur_sc + 5'd1 : cur_sc;
            fraction_count_d = cur_fc + 3'd1;
            if (fraction_count_d >= FRACTION_LIMIT) begin
              push.count       = 2'd1;
              push.res0        = make_number(cur_neg, digit_value_d, scale_count_d);
              in_number_d      = 1'b0;
              is_negative_d    = 1'b0;
              digit_value_d    = '0;
              fraction_count_d = '0;
              scale_count_d    = '0;
            end
          end
        end
      end else begin
        if (in_number_q) begin
          push.count       = 2'd1;
          push.res0        = make_number(is_negative_q, digit_value_q, scale_count_q);
          in_number_d      = 1'b0;
          is_negative_d    = 1'b0;
          digit_value_d    = '0;
          fraction_count_d = '0;
          scale_count_d    = '0;
        end
        if (byte_q == extend_char_i) begin
          extend_pending_d = 1'b1;
        end else if (in_number_q) begin
          push.count = 2'd2;
          push.res1  = make_func(KIND_FUNC, byte_q);
        end else begin
          push.count = 2'd1;
          push.res0  = make_func(KIND_FUNC, byte_q);
        end
      end
      if (push.count == 2'd1) begin
        push.res0.last = 1'b1;
      end else if (push.count == 2'd2) begin
        push.res1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q      <= 1'b0;
      is_negative_q    <= 1'b0;
      digit_value_q    <= '0;
      fraction_count_q <= '0;
      scale_count_q    <= '0;
      extend_pending_q <= 1'b0;
    end else begin
      in_number_q      <= in_number_d;
      is_negative_q    <= is_negative_d;
      digit_value_q    <= digit_value_d;
      fraction_count_q <= fraction_count_d;
      scale_count_q    <= scale_count_d;
      extend_pending_q <= extend_pending_d;
    end
  end

  assign push_o = push;

  a_fraction_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fraction_count_q < FRACTION_LIMIT)
    else $error("fraction count out of range");

  a_extend_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && extend_pending_q) |=> !extend_pending_q)
    else $error("pending extend not consumed");

  a_idle_number_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_number_q |-> (digit_value_q == '0 && !is_negative_q && scale_count_q == '0))
    else $error("number state left behind");

endmodule

// ===== rtl/core/pct_res_fifo.sv =====
module pct_res_fifo
  import pct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  result_t    mem_q [4];
  logic [1:0] wr_q;
  logic [1:0] rd_q;
  logic [2:0] count_q;
  logic       pop;
  logic [2:0] count_after_pop;

  assign out_valid_o     = (count_q != 3'd0);
  assign pop             = out_valid_o && out_ready_i;
  assign count_after_pop = count_q - {2'd0, pop};
  assign room_o          = (count_after_pop <= 3'd2);
  assign out_res_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + push_i.count;
      rd_q    <= rd_q + {1'b0, pop};
      count_q <= count_after_pop + {1'b0, push_i.count};
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("result queue overfilled");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o && push_i.count != 2'd3)
    else $error("push without room");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd2) |-> (push_i.res1.last && !push_i.res0.last))
    else $error("last flag misplaced in result pair");

endmodule

// ===== rtl/core/program_cell_tokenizer.sv =====
// Program cell tokenizer: takes one text byte per cycle and emits number and function cells
// on the output channel, one cell per transaction, with last set on the final cell of a byte.
// A byte is registered, then decoded and its cells written to a four-entry result queue once
// the queue has room, so with a ready consumer a byte is taken every cycle. A byte that
// closes a number and is itself a function yields two cells, which leave the queue number
// cell first; input stalls only when the queue cannot take two more cells. Number cells
// carry a saturated signed mantissa and a decimal scale (0..18); the consumer divides by
// ten to that power. The user is to write the extend byte (register 0, reset '#') over the
// APB port only while the block is idle; the block itself does not enforce this.
module program_cell_tokenizer
  import pct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         text_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         cell_kind_o,
  output logic [7:0]         func_code_o,
  output logic signed [63:0] mantissa_o,
  output logic [4:0]         decimal_scale_o,
  output logic               last_o
);

  logic [7:0] extend_char;
  logic       room;
  push_t      push;
  result_t    out_res;

  pct_cfg_regs u_cfg_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .extend_char_o (extend_char)
  );

  pct_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .extend_char_i (extend_char),
    .room_i        (room),
    .push_o        (push)
  );

  pct_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  assign cell_kind_o     = out_res.kind;
  assign func_code_o     = out_res.func_code;
  assign mantissa_o      = out_res.mantissa;
  assign decimal_scale_o = out_res.scale;
  assign last_o          = out_res.last;

endmodule

// ===== bench/program_cell_tokenizer_tb.sv =====
module program_cell_tokenizer_tb;
  import pct_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam logic [2:0]  EXTEND_CHAR_ADDR = {REG_EXTEND_CHAR, 2'b00};

  typedef struct {
    logic [7:0] b;
    bit         typed;
    cell_kind_e kind;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte = '0;
  int          text_tag = -1;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [1:0]  cell_kind_o;
  logic [7:0]  func_code_o;
  logic signed [63:0] mantissa_o;
  logic [4:0]  decimal_scale_o;
  logic        last_o;

  // tokenizer state as predicted
  logic [7:0]  cfg_extend = EXTEND_RESET;
  logic        in_num = 1'b0;
  logic        neg = 1'b0;
  logic        ext_pend = 1'b0;
  logic [62:0] mag = '0;
  logic [2:0]  frac_cnt = '0;
  logic [4:0]  scale_cnt = '0;

  result_t     step_cells[$];
  result_t     cells_due[$];
  dir_row_t    dir_rows[$];

  int          errors = 0;
  int          sent = 0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  program_cell_tokenizer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .text_byte_i     (text_byte),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .cell_kind_o     (cell_kind_o),
    .func_code_o     (func_code_o),
    .mantissa_o      (mantissa_o),
    .decimal_scale_o (decimal_scale_o),
    .last_o          (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit is_num_byte(input logic [7:0] b);
    return (b == CHAR_UNDERSCORE) || (b == CHAR_DOT) || (b >= CHAR_ZERO && b <= CHAR_NINE);
  endfunction

  function automatic result_t func_cell(input cell_kind_e k, input logic [7:0] code);
    result_t r;
    r.kind      = k;
    r.func_code = code;
    r.mantissa  = '0;
    r.scale     = '0;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic result_t number_cell();
    result_t r;
    r.kind      = KIND_NUMBER;
    r.func_code = '0;
    r.mantissa  = neg ? 64'sd0 - {1'b0, mag} : {1'b0, mag};
    r.scale     = scale_cnt;
    r.last      = 1'b0;
    in_num    = 1'b0;
    neg       = 1'b0;
    mag       = '0;
    frac_cnt  = '0;
    scale_cnt = '0;
    return r;
  endfunction

  // cells caused by one text byte land in step_cells
  function automatic void tokenize(input logic [7:0] b);
    logic [62:0] d;
    step_cells.delete();
    if (ext_pend) begin
      ext_pend = 1'b0;
      step_cells.push_back(func_cell(KIND_EXT_FUNC, b));
    end else if (is_num_byte(b)) begin
      if (!in_num) begin
        in_num    = 1'b1;
        neg       = 1'b0;
        mag       = '0;
        frac_cnt  = '0;
        scale_cnt = '0;
      end
      if (b == CHAR_UNDERSCORE) begin
        neg = 1'b1;
      end else if (b == CHAR_DOT) begin
        frac_cnt = 3'd1;
      end else begin
        d = 63'(b - CHAR_ZERO);
        if (mag > (DIGIT_MAX - d) / 63'd10) mag = DIGIT_MAX;
        else mag = mag * 63'd10 + d;
        if (frac_cnt != 0) begin
          if (scale_cnt < SCALE_MAX) scale_cnt = scale_cnt + 5'd1;
          frac_cnt = frac_cnt + 3'd1;
          if (frac_cnt >= FRACTION_LIMIT) step_cells.push_back(number_cell());
        end
      end
    end else begin
      if (in_num) step_cells.push_back(number_cell());
      if (b == cfg_extend) ext_pend = 1'b1;
      else step_cells.push_back(func_cell(KIND_FUNC, b));
    end
    if (step_cells.size() != 0) step_cells[step_cells.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // input transaction: predict
  always @(posedge clk_i) begin : accept_mon
    result_t typed_cell;
    if (rst_ni && in_valid && in_ready_o) begin
      tokenize(text_byte);
      if (text_tag >= 0) begin
        typed_cell = func_cell(dir_rows[text_tag].kind, text_byte);
        typed_cell.last = 1'b1;
        cells_due.push_back(typed_cell);
      end else begin
        foreach (step_cells[i]) cells_due.push_back(step_cells[i]);
      end
    end
  end

  // output transaction: compare with oldest expectation
  always @(posedge clk_i) begin : cell_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (cells_due.size() == 0) begin
        $error("unexpected cell: kind %0d code %0h mantissa %0h scale %0d",
               cell_kind_o, func_code_o, mantissa_o, decimal_scale_o);
        errors++;
      end else begin
        want = cells_due.pop_front();
        check_field("cell_kind", want.kind, cell_kind_o);
        check_field("func_code", want.func_code, func_code_o);
        check_field("mantissa", want.mantissa, mantissa_o);
        check_field("decimal_scale", want.scale, decimal_scale_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input int tag = -1);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    text_tag  <= tag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == EXTEND_CHAR_ADDR) cfg_extend = data[7:0];
  endtask

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_other();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_num_byte(b));
    return b;
  endfunction

  task automatic send_word();
    logic [7:0] w[$];
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      repeat ($urandom_range(0, 6)) w.push_back(rand_digit());
      if ($urandom_range(0, 1)) begin
        w.push_back(CHAR_DOT);
        repeat ($urandom_range(0, 6)) w.push_back(rand_digit());
        if ($urandom_range(0, 5) == 0) begin
          w.push_back(CHAR_DOT);
          repeat ($urandom_range(1, 6)) w.push_back(rand_digit());
        end
      end
      if ($urandom_range(0, 3) == 0) w.insert($urandom_range(0, w.size()), CHAR_UNDERSCORE);
      if (w.size() == 0) w.push_back(rand_digit());
      if ($urandom_range(0, 9) < 7) w.push_back(rand_other());
    end else if (pick < 58) begin
      // up to 24 digits, long enough at the top of the range to saturate the mantissa
      repeat ($urandom_range(17, 24)) w.push_back(rand_digit());
      if ($urandom_range(0, 1)) w.push_front(CHAR_UNDERSCORE);
      w.push_back(rand_other());
    end else if (pick < 64) begin
      // fraction groups short of the limit; with five or more groups the scale saturates at 18
      repeat ($urandom_range(4, 6)) begin
        w.push_back(CHAR_DOT);
        repeat (4) w.push_back(rand_digit());
      end
      w.push_back(rand_other());
    end else if (pick < 79) begin
      w.push_back(cfg_extend);
      w.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) w.push_back(8'($urandom_range(0, 255)));
    end
    foreach (w[i]) send_byte(w[i]);
  endtask

  function automatic void add_row(input logic [7:0] b, input bit typed = 1'b0,
                                  input cell_kind_e kind = KIND_FUNC);
    dir_row_t r;
    r.b     = b;
    r.typed = typed;
    r.kind  = kind;
    dir_rows.push_back(r);
  endfunction

  initial begin : main
    logic [7:0] ext_vals[8];
    int target;
    ext_vals = '{8'h00, 8'hFF, CHAR_DOT, "5", CHAR_UNDERSCORE, 8'($urandom_range(0, 255)),
                 EXTEND_RESET, 8'($urandom_range(0, 255))};

    add_row(8'h00, 1'b1);
    add_row(8'hFF, 1'b1);
    add_row("#");
    add_row("7", 1'b1, KIND_EXT_FUNC);
    add_row("#");
    add_row("#", 1'b1, KIND_EXT_FUNC);
    add_row("_");
    add_row("+");
    add_row(".");
    add_row(" ");
    add_row("1");
    add_row("_");
    add_row(".");
    add_row("5");
    add_row("0");
    add_row(".");
    add_row("2");
    add_row("9");
    add_row("9");
    add_row("9");
    add_row("9");
    add_row("3");
    add_row("#");
    add_row(".", 1'b1, KIND_EXT_FUNC);
    add_row(8'h80);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].typed ? i : -1);
    text_tag <= -1;
    wait_idle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 75; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 75; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      apb_write(EXTEND_CHAR_ADDR, {24'd0, ext_vals[phase]});
      target = sent + 210;
      while (sent < target) begin
        send_word();
        if (phase == 3 && sent > target - 110 && sent < target - 100) wait_idle();
      end
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
